/* design/mfsgd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfsgd_pkg
// Shared types and opcodes for the factor table SGD update block.
// ----------------------------------------------------------------------------
package mfsgd_pkg;

  typedef enum logic [2:0] {
    OP_WR_USER = 3'd0,
    OP_WR_ITEM = 3'd1,
    OP_TRAIN   = 3'd2,
    OP_RD_USER = 3'd3,
    OP_RD_ITEM = 3'd4
  } op_e;

  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_RIDGE      = 2'd1;
  localparam logic [1:0] REG_DIMS       = 2'd2;

  // datapath phase selects
  typedef enum logic [2:0] {
    DP_IDLE,
    DP_DOT,
    DP_ERR,
    DP_MUL1,
    DP_MUL2,
    DP_MUL3,
    DP_ADD
  } dp_phase_e;

  // controller to datapath
  typedef struct packed {
    logic      load;
    dp_phase_e phase;
    logic      acc_clear;
    logic      wr_user;
    logic      wr_item;
    logic      res_valid;
    logic      res_zero;
  } dp_cmd_t;

endpackage
`default_nettype wire

/* design/mfsgd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfsgd_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module mfsgd_ram #(
  parameter int Width = 32,
  parameter int Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read first port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

/* design/mfsgd_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfsgd_datapath
// Factor tables, dot product accumulator and element update arithmetic.
// ----------------------------------------------------------------------------
module mfsgd_datapath
  import mfsgd_pkg::*;
#(
  parameter int AddrW = 14
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  input  wire logic [AddrW-1:0]  uaddr_i,
  input  wire logic [AddrW-1:0]  iaddr_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [15:0]       lr_i,
  input  wire logic [15:0]       ridge_i,
  input  wire logic              rd_item_i,
  output logic                   valid_o,
  output logic signed [31:0]     data_o,
  output logic                   sat_o
);

  logic signed [31:0] u_rd, v_rd, ram_u_wd, ram_v_wd;
  logic signed [31:0] u_q, v_q, rating_q, err_q;
  logic signed [31:0] unew_q, vnew_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] p_euv_q, p_ruu_q, p_evu_q, p_rvv_q;
  logic signed [63:0] tu_q, tv_q;
  logic sat_q;

  logic [AddrW-1:0] uaddr, iaddr;
  assign uaddr = uaddr_i;
  assign iaddr = iaddr_i;

  // write data: element write or updated element
  assign ram_u_wd = (cmd_i.phase == DP_ADD) ? unew_q : value_i;
  assign ram_v_wd = (cmd_i.phase == DP_ADD) ? vnew_q : value_i;

  mfsgd_ram #(.Width(32), .Depth(1 << AddrW)) u_user_ram (
    .clk_i, .we_i(cmd_i.wr_user), .addr_i(uaddr), .wdata_i(ram_u_wd), .rdata_o(u_rd)
  );
  mfsgd_ram #(.Width(32), .Depth(1 << AddrW)) u_item_ram (
    .clk_i, .we_i(cmd_i.wr_item), .addr_i(iaddr), .wdata_i(ram_v_wd), .rdata_o(v_rd)
  );

  function automatic logic signed [31:0] clip(input logic signed [65:0] x,
                                              output logic s);
    s = 1'b0;
    if (x > 66'sh0_7FFF_FFFF) begin
      s = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (x < -66'sh0_8000_0000) begin
      s = 1'b1;
      return -32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  logic signed [65:0] err_wide, uadd, vadd;
  logic signed [63:0] du, dv, uprod;
  logic s_err, s_u, s_v;
  logic signed [31:0] err_c, unew_c, vnew_c;

  always_comb begin
    uprod    = u_rd * v_rd;
    err_wide = 66'(rating_q) - 66'(acc_q);
    err_c    = clip(err_wide, s_err);
    du       = (tu_q >>> 16) * $signed({1'b0, lr_i});
    dv       = (tv_q >>> 16) * $signed({1'b0, lr_i});
    uadd     = 66'(u_q) + 66'(du >>> 16);
    vadd     = 66'(v_q) + 66'(dv >>> 16);
    unew_c   = clip(uadd, s_u);
    vnew_c   = clip(vadd, s_v);
  end

  // accumulation and update pipeline over one element
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rating_q <= value_i;
    end
    if (cmd_i.acc_clear) begin
      acc_q <= '0;
    end else if (cmd_i.phase == DP_DOT) begin
      acc_q <= acc_q + (uprod >>> 16);
    end
    if (cmd_i.phase == DP_ERR) begin
      err_q <= err_c;
    end
    if (cmd_i.phase == DP_MUL1) begin
      u_q     <= u_rd;
      v_q     <= v_rd;
      p_euv_q <= err_q * v_rd;
      p_evu_q <= err_q * u_rd;
    end
    if (cmd_i.phase == DP_MUL2) begin
      p_ruu_q <= $signed({1'b0, ridge_i}) * u_q;
      p_rvv_q <= $signed({1'b0, ridge_i}) * v_q;
    end
    if (cmd_i.phase == DP_MUL3) begin
      tu_q <= p_euv_q - p_ruu_q;
      tv_q <= p_evu_q - p_rvv_q;
    end
    unew_q <= unew_c;
    vnew_q <= vnew_c;
  end

  // saturation flag and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q   <= 1'b0;
      valid_o <= 1'b0;
      data_o  <= '0;
      sat_o   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        sat_q <= 1'b0;
      end else if (cmd_i.phase == DP_ERR) begin
        sat_q <= sat_q | s_err;
      end else if (cmd_i.phase == DP_ADD) begin
        sat_q <= sat_q | s_u | s_v;
      end
      valid_o <= cmd_i.res_valid;
      if (cmd_i.res_valid) begin
        if (cmd_i.res_zero) begin
          data_o <= '0;
          sat_o  <= 1'b0;
        end else if (cmd_i.phase == DP_IDLE) begin
          data_o <= rd_item_i ? v_rd : u_rd;
          sat_o  <= 1'b0;
        end else begin
          data_o <= err_q;
          sat_o  <= sat_q;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* design/mfsgd_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfsgd_ctrl
// Sequencer for element access and the two train passes.
// ----------------------------------------------------------------------------
module mfsgd_ctrl
  import mfsgd_pkg::*;
#(
  parameter int Users = 1024,
  parameter int Items = 1024,
  parameter int Dim   = 16,
  parameter int DW    = 9,
  parameter int AddrW = 14
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [2:0]        opcode_i,
  input  wire logic [9:0]        user_index_i,
  input  wire logic [9:0]        item_index_i,
  input  wire logic [3:0]        dim_index_i,
  input  wire logic [4:0]        dims_i,
  output logic                   busy_o,
  output dp_cmd_t                cmd_o,
  output logic [AddrW-1:0]       uaddr_o,
  output logic [AddrW-1:0]       iaddr_o,
  output logic                   rd_item_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DOT, S_DOT_LAST, S_ERR, S_UPD_RD, S_MUL1, S_MUL2, S_MUL3,
    S_ADD, S_WB, S_DONE
  } state_e;

  state_e state_q;
  logic [DW-1:0] cnt_q, dcnt_q;
  logic [AddrW-1:0] ubase_q, ibase_q;
  logic [2:0] op_q;
  logic [AddrW-1:0] uaddr_e, iaddr_e;

  logic u_ok, i_ok, d_ok, accept;
  logic [DW-1:0] dsat;
  assign u_ok   = 32'(user_index_i) < 32'(Users);
  assign i_ok   = 32'(item_index_i) < 32'(Items);
  assign d_ok   = 32'(dim_index_i) < 32'(Dim);
  assign dsat   = (32'(dims_i) > 32'(Dim)) ? DW'(Dim) : DW'(dims_i);
  assign accept = start_i && !busy_o;
  assign uaddr_e = AddrW'(32'(user_index_i) * Dim + 32'(dim_index_i));
  assign iaddr_e = AddrW'(32'(item_index_i) * Dim + 32'(dim_index_i));

  assign busy_o    = (state_q != S_IDLE);
  assign rd_item_o = (op_q == 3'(OP_RD_ITEM));

  // addresses: base row plus element count, or the command's element address in idle
  always_comb begin
    uaddr_o = ubase_q + AddrW'(cnt_q);
    iaddr_o = ibase_q + AddrW'(cnt_q);
    if (state_q == S_IDLE) begin
      uaddr_o = uaddr_e;
      iaddr_o = iaddr_e;
    end
  end

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.load = accept;
    cmd_o.phase = DP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.acc_clear = 1'b1;
          case (opcode_i)
            3'(OP_WR_USER): begin
              cmd_o.wr_user = u_ok && d_ok;
            end
            3'(OP_WR_ITEM): begin
              cmd_o.wr_item = i_ok && d_ok;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd_o.res_valid = 1'b1;
        cmd_o.res_zero  = !((op_q == 3'(OP_RD_USER)) || (op_q == 3'(OP_RD_ITEM)))
                          || ubase_q[0] == 1'b1;
      end
      // first row read is in flight, nothing to accumulate yet
      S_DOT:      cmd_o.phase = DP_IDLE;
      S_DOT_LAST: cmd_o.phase = DP_DOT;
      S_ERR:      cmd_o.phase = DP_ERR;
      S_MUL1:     cmd_o.phase = DP_MUL1;
      S_MUL2:     cmd_o.phase = DP_MUL2;
      S_MUL3:     cmd_o.phase = DP_MUL3;
      S_WB: begin
        cmd_o.phase   = DP_ADD;
        cmd_o.wr_user = 1'b1;
        cmd_o.wr_item = 1'b1;
      end
      S_DONE: begin
        cmd_o.phase     = DP_ERR;
        cmd_o.res_valid = 1'b1;
        cmd_o.res_zero  = 1'b0;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      dcnt_q  <= '0;
      ubase_q <= '0;
      ibase_q <= '0;
      op_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q   <= opcode_i;
            cnt_q  <= '0;
            dcnt_q <= dsat;
            // bit 0 of base marks an invalid access for reads
            ubase_q <= '0;
            ibase_q <= '0;
            if (opcode_i == 3'(OP_TRAIN)) begin
              ubase_q <= AddrW'(32'(user_index_i) * Dim);
              ibase_q <= AddrW'(32'(item_index_i) * Dim);
              if (!(u_ok && i_ok)) begin
                state_q <= S_READ;
                op_q    <= 3'd7;
              end else if (dsat == '0) begin
                state_q <= S_ERR;
              end else begin
                state_q <= S_DOT;
              end
            end else begin
              state_q <= S_READ;
              if (opcode_i == 3'(OP_RD_USER)) ubase_q[0] <= !(u_ok && d_ok);
              if (opcode_i == 3'(OP_RD_ITEM)) ubase_q[0] <= !(i_ok && d_ok);
            end
          end
        end
        S_READ: state_q <= S_IDLE;
        S_DOT: begin
          // read of element cnt lands next cycle
          state_q <= S_DOT_LAST;
          cnt_q   <= cnt_q + 1'b1;
        end
        S_DOT_LAST: begin
          if (cnt_q == dcnt_q) begin
            state_q <= S_ERR;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_ERR:    state_q <= (dcnt_q == '0) ? S_DONE : S_UPD_RD;
        S_UPD_RD: state_q <= S_MUL1;
        S_MUL1:   state_q <= S_MUL2;
        S_MUL2:   state_q <= S_MUL3;
        S_MUL3:   state_q <= S_ADD;
        S_ADD:    state_q <= S_WB;
        S_WB: begin
          if (cnt_q + 1'b1 == dcnt_q) begin
            state_q <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_UPD_RD;
          end
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("busy not raised");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (cnt_q < dcnt_q)) else $error("update count overrun");
  a_wb_only_train: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (op_q == 3'(OP_TRAIN))) else $error("writeback outside train");

endmodule
`default_nettype wire

/* design/matrix_factorization_sgd_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_update
// Latent factor tables with element access and one SGD train step per command.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  command  | start_i / busy_o   | opcode_i user_index_i item_index_i dim_index_i value_i
//  result   | done_o strobe      | data_o saturated_o
//  config   | cfg_we_i           | cfg_index_i cfg_data_i
//
// element writes, reads and ignored commands pass through S_READ alone
// train, d = dims_in_use: a priming read (S_DOT), d dot products (S_DOT_LAST), S_ERR,
// then per updated element S_UPD_RD, S_MUL1, S_MUL2, S_MUL3, S_ADD, S_WB, then S_DONE;
// with d zero only S_ERR and S_DONE; each factor table has one port, so elements go in turn
// the result strobe rises as busy falls, lasts one cycle, cannot be stalled
// reset clears the controller, config registers and result outputs; factor tables start undefined
// ----------------------------------------------------------------------------
module matrix_factorization_sgd_update
  import mfsgd_pkg::*;
#(
  parameter int USERS = 1024,
  parameter int ITEMS = 1024,
  parameter int DIM   = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [2:0]         opcode_i,
  input  wire logic [9:0]         user_index_i,
  input  wire logic [9:0]         item_index_i,
  input  wire logic [3:0]         dim_index_i,
  input  wire logic signed [31:0] value_i,
  output logic                    done_o,
  output logic signed [31:0]      data_o,
  output logic                    saturated_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  localparam int Rows  = (USERS > ITEMS) ? USERS : ITEMS;
  localparam int AddrW = $clog2(Rows * DIM) < 1 ? 1 : $clog2(Rows * DIM);
  localparam int DW    = $clog2(DIM + 1) + 1;

  logic [15:0] lr_q, ridge_q;
  logic [4:0]  dims_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= 16'd655;
      ridge_q <= 16'd655;
      dims_q  <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LEARN_RATE: lr_q    <= cfg_data_i;
        REG_RIDGE:      ridge_q <= cfg_data_i;
        REG_DIMS:       dims_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  logic [AddrW-1:0] uaddr, iaddr;
  logic rd_item;

  mfsgd_ctrl #(.Users(USERS), .Items(ITEMS), .Dim(DIM), .DW(DW), .AddrW(AddrW)) u_ctrl (
    .clk_i, .rst_ni, .start_i, .opcode_i, .user_index_i, .item_index_i, .dim_index_i,
    .dims_i(dims_q), .busy_o, .cmd_o(cmd), .uaddr_o(uaddr), .iaddr_o(iaddr),
    .rd_item_o(rd_item)
  );

  mfsgd_datapath #(.AddrW(AddrW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .uaddr_i(uaddr), .iaddr_i(iaddr), .value_i,
    .lr_i(lr_q), .ridge_i(ridge_q), .rd_item_i(rd_item),
    .valid_o(done_o), .data_o, .sat_o(saturated_o)
  );

endmodule
`default_nettype wire

/* tb/sv/matrix_factorization_sgd_update_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_update_test
// Drives element writes, reads and train commands into the factor table SGD
// block, predicts untyped results with a bit-exact fixed-point model of the
// update, and checks data and saturation on each result strobe.
// ----------------------------------------------------------------------------
module matrix_factorization_sgd_update_test;
  import mfsgd_pkg::*;

  localparam int NDIM      = 16;
  localparam int POOL      = 6;
  localparam int WDOG_MAX  = 4000;
  localparam int PHASE_LEN = 330;

  typedef struct {
    int  data;
    bit  sat;
  } factor_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [9:0]  urow;
    logic [9:0]  irow;
    logic [3:0]  dim;
    int          val;
    bit          typed;
    int          exp_data;
    bit          exp_sat;
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  opcode_i = '0;
  logic [9:0]  user_index_i = '0;
  logic [9:0]  item_index_i = '0;
  logic [3:0]  dim_index_i = '0;
  logic signed [31:0] value_i = '0;
  logic        done_o;
  logic signed [31:0] data_o;
  logic        saturated_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  matrix_factorization_sgd_update dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  int          user_tab[NDIM*1024];
  int          item_tab[NDIM*1024];
  bit [15:0]   lr_q = 16'd655;
  bit [15:0]   ridge_q = 16'd655;
  bit [4:0]    dims_q = 5'd16;
  logic [9:0]  user_pool[POOL];
  logic [9:0]  item_pool[POOL];

  factor_result_t pending_q[$];
  int errors, n_sent, n_results, n_train, n_sat;
  bit gaps_on;

  task automatic report(string what, int got, int want);
    errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  function automatic int clip32(longint x, inout bit s);
    if (x > longint'(32'sh7fffffff)) begin
      s = 1;
      return 32'sh7fffffff;
    end
    if (x < -longint'(64'h80000000)) begin
      s = 1;
      return 32'sh80000000;
    end
    return int'(x);
  endfunction

  function automatic int sgd_elem(int self_v, int other_v, int err, inout bit s);
    longint t;
    t = longint'(err) * longint'(other_v) - longint'(ridge_q) * longint'(self_v);
    t = t >>> 16;
    t = (t * longint'(lr_q)) >>> 16;
    return clip32(longint'(self_v) + t, s);
  endfunction

  // bit-exact response of the block to one command
  function automatic factor_result_t predict_factor(logic [2:0] op, logic [9:0] ur,
                                                    logic [9:0] ir, logic [3:0] d, int v);
    factor_result_t r;
    longint acc;
    int nd, err, uo, vo, ub, ib;
    r.data = 0;
    r.sat = 0;
    ub = int'(ur) * NDIM;
    ib = int'(ir) * NDIM;
    case (op)
      OP_WR_USER: user_tab[ub + d] = v;
      OP_WR_ITEM: item_tab[ib + d] = v;
      OP_RD_USER: r.data = user_tab[ub + d];
      OP_RD_ITEM: r.data = item_tab[ib + d];
      OP_TRAIN: begin
        nd = (dims_q > NDIM) ? NDIM : int'(dims_q);
        acc = 0;
        for (int k = 0; k < nd; k++)
          acc += (longint'(user_tab[ub + k]) * longint'(item_tab[ib + k])) >>> 16;
        err = clip32(longint'(v) - acc, r.sat);
        for (int k = 0; k < nd; k++) begin
          uo = user_tab[ub + k];
          vo = item_tab[ib + k];
          user_tab[ub + k] = sgd_elem(uo, vo, err, r.sat);
          item_tab[ib + k] = sgd_elem(vo, uo, err, r.sat);
        end
        r.data = err;
      end
      default: ;
    endcase
    return r;
  endfunction

  // one command transfer; start stays high after the transfer unless a gap is inserted
  task automatic issue(cmd_row_t c);
    factor_result_t r;
    @(negedge clk_i);
    start_i      <= 1'b1;
    opcode_i     <= c.op;
    user_index_i <= c.urow;
    item_index_i <= c.irow;
    dim_index_i  <= c.dim;
    value_i      <= c.val;
    do @(posedge clk_i); while (busy_o);
    r = predict_factor(c.op, c.urow, c.irow, c.dim, c.val);
    if (c.typed) begin
      r.data = c.exp_data;
      r.sat = c.exp_sat;
    end
    pending_q.push_back(r);
    n_sent++;
    if (c.op == OP_TRAIN) n_train++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  endtask

  task automatic drain_and_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_LEARN_RATE: lr_q = val;
      REG_RIDGE:      ridge_q = val;
      REG_DIMS:       dims_q = val[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 32'h3ffff)) - 32'h20000;
      4, 5:       return int'($urandom_range(0, 32'h3ffffff)) - 32'h2000000;
      6, 7:       return int'($urandom());
      8:          return 32'sh7fffffff - int'($urandom_range(0, 3));
      default:    return 32'sh80000000 + int'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic cmd_row_t rand_cmd();
    cmd_row_t c;
    c.typed = 0;
    c.urow = user_pool[$urandom_range(0, POOL-1)];
    c.irow = item_pool[$urandom_range(0, POOL-1)];
    c.dim = 4'($urandom_range(0, NDIM-1));
    c.val = rand_value();
    case ($urandom_range(0, 19))
      0, 1, 2:    c.op = OP_WR_USER;
      3, 4, 5:    c.op = OP_WR_ITEM;
      6, 7:       c.op = OP_RD_USER;
      8, 9:       c.op = OP_RD_ITEM;
      10: begin
        // write to any row; never read back unless it is a pool row
        c.op = $urandom_range(0, 1) ? OP_WR_USER : OP_WR_ITEM;
        c.urow = 10'($urandom_range(0, 1023));
        c.irow = 10'($urandom_range(0, 1023));
      end
      11:         c.op = 3'($urandom_range(5, 7));
      default:    c.op = OP_TRAIN;
    endcase
    return c;
  endfunction

  // result checking
  always @(posedge clk_i) begin
    factor_result_t e;
    if (rst_ni && done_o) begin
      n_results++;
      if (saturated_o) n_sat++;
      if (pending_q.size() == 0) begin
        report("unexpected result", data_o, 0);
      end else begin
        e = pending_q.pop_front();
        if (data_o !== e.data) report("data", data_o, e.data);
        if (saturated_o !== e.sat) report("saturated", int'(saturated_o), int'(e.sat));
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  cmd_row_t directed[$];
  cmd_row_t c;
  logic [15:0] cfg_lr[5], cfg_rg[5], cfg_dm[5];

  initial begin
    gaps_on = 1;
    user_pool = '{10'd0, 10'd1023, 10'h155, 10'h2aa, 10'd0, 10'd0};
    item_pool = '{10'd0, 10'd1023, 10'h2aa, 10'h155, 10'd0, 10'd0};
    for (int p = 4; p < POOL; p++) begin
      user_pool[p] = 10'($urandom_range(1, 1022));
      item_pool[p] = 10'($urandom_range(1, 1022));
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill every pool row so that no read or train sees an unwritten entry
    for (int p = 0; p < POOL; p++)
      for (int k = 0; k < NDIM; k++) begin
        c = '{op: OP_WR_USER, urow: user_pool[p], irow: 10'd0, dim: 4'(k),
              val: int'($urandom_range(0, 32'h1ffff)) - 32'h10000,
              typed: 1, exp_data: 0, exp_sat: 0};
        issue(c);
        c.op = OP_WR_ITEM;
        c.irow = item_pool[p];
        c.val = int'($urandom_range(0, 32'h1ffff)) - 32'h10000;
        issue(c);
      end

    // directed: extremes, every opcode, unused opcodes, error clipping
    directed = '{
      '{OP_TRAIN,   10'd0,    10'd0,    4'd0,  32'sh00010000, 0, 0, 0},
      '{OP_WR_USER, 10'd0,    10'd0,    4'd0,  32'sh7fffffff, 1, 0, 0},
      '{OP_RD_USER, 10'd0,    10'd0,    4'd0,  0,             1, 32'sh7fffffff, 0},
      '{OP_WR_ITEM, 10'd1023, 10'd1023, 4'd15, 32'sh80000000, 1, 0, 0},
      '{OP_RD_ITEM, 10'd1023, 10'd1023, 4'd15, 0,             1, 32'sh80000000, 0},
      '{OP_WR_ITEM, 10'd0,    10'd0,    4'd0,  32'sh7fffffff, 1, 0, 0},
      '{OP_TRAIN,   10'd0,    10'd0,    4'd0,  32'sh80000000, 0, 0, 0},
      '{OP_TRAIN,   10'd1023, 10'd1023, 4'd0,  32'sh7fffffff, 0, 0, 0},
      '{OP_RD_USER, 10'd0,    10'd0,    4'd0,  0,             0, 0, 0},
      '{3'd5,       10'd1023, 10'd0,    4'd15, 32'sh7fffffff, 1, 0, 0},
      '{3'd6,       10'd0,    10'd1023, 4'd0,  32'sh80000000, 1, 0, 0},
      '{3'd7,       10'd1023, 10'd1023, 4'd15, -1,            1, 0, 0},
      '{OP_WR_USER, 10'd0,    10'd0,    4'd0,  32'sh00020000, 1, 0, 0},
      '{OP_WR_ITEM, 10'd0,    10'd0,    4'd0,  32'sh00030000, 1, 0, 0},
      '{OP_TRAIN,   10'd0,    10'd0,    4'd0,  0,             0, 0, 0},
      '{OP_RD_ITEM, 10'd0,    10'd0,    4'd0,  0,             0, 0, 0}
    };
    foreach (directed[n]) issue(directed[n]);

    // register settings per phase: over-range dims, extremes, zero dims, random
    cfg_lr = '{16'd655,  16'hffff, 16'd0,    16'd0, 16'd0};
    cfg_rg = '{16'd655,  16'hffff, 16'd0,    16'd0, 16'd0};
    cfg_dm = '{16'hffff, 16'd16,   16'd0,    16'd1, 16'd0};
    cfg_lr[3] = 16'($urandom_range(0, 16'hffff));
    cfg_rg[3] = 16'($urandom_range(0, 16'hffff));
    cfg_lr[4] = 16'($urandom_range(0, 16'h3fff));
    cfg_rg[4] = 16'($urandom_range(0, 16'h3fff));
    cfg_dm[4] = {11'($urandom_range(0, 11'h7ff)), 5'($urandom_range(1, 16))};
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_idle();
      set_reg(REG_LEARN_RATE, cfg_lr[ph]);
      set_reg(REG_RIDGE, cfg_rg[ph]);
      set_reg(REG_DIMS, cfg_dm[ph]);
      gaps_on = (ph != 4);
      for (int n = 0; n < ((ph == 4) ? PHASE_LEN/2 : PHASE_LEN); n++) issue(rand_cmd());
    end

    drain_and_idle();
    repeat (200) @(posedge clk_i);
    $display("sent %0d commands (%0d train), checked %0d results, %0d saturated",
             n_sent, n_train, n_results, n_sat);
    $display("covered five register settings including zero, full-scale and over-range dims");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
